@@ sv/reflected_frame_matcher_macros.svh @@
// Assertion macros for the reflected frame matcher.
// Used by the top level; needs clk_i and rst_ni in the including module.
`ifndef REFLECTED_FRAME_MATCHER_MACROS_SVH
`define REFLECTED_FRAME_MATCHER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define RFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rfm assertion failed");
// next-cycle implication
`define RFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rfm assertion failed");
`else
`define RFM_ASSERT_NOW(label, ante, cons)
`define RFM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/rfm_pkg.sv @@
// Package for the reflected frame matcher: register indexes, header
// offsets and protocol constants. No dependencies.
package rfm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned PosW     = 7;
  localparam int unsigned SeqW     = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_MAC  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PEER_MAC   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_ADDR = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PEER_ADDR  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_PORT = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PEER_PORT  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_UDP_MODE   = 3'd6;

  // header layout
  localparam logic [PosW-1:0] MAC_SRC_OFS      = 7'd6;
  localparam logic [PosW-1:0] ETYPE_OFS        = 7'd12;
  localparam logic [PosW-1:0] ETYPE_LO_OFS     = 7'd13;
  localparam logic [PosW-1:0] L3_OFS           = 7'd14;
  localparam logic [PosW-1:0] VLAN_ET_OFS      = 7'd16;
  localparam logic [PosW-1:0] VLAN_ET_LO       = 7'd17;
  localparam logic [PosW-1:0] L3_VLAN_OFS      = 7'd18;
  localparam logic [PosW-1:0] UDP_HEADER_BYTES = 7'd8;
  localparam logic [PosW-1:0] POS_MAX          = 7'd127;

  // offsets inside the IPv4 header
  localparam logic [PosW-1:0] IP_PROTO_REL = 7'd9;
  localparam logic [PosW-1:0] IP_SRC_REL   = 7'd12;
  localparam logic [PosW-1:0] IP_DST_REL   = 7'd16;
  localparam logic [PosW-1:0] IP_END_REL   = 7'd20;

  localparam logic [15:0] ETYPE_VLAN   = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
  localparam logic [3:0]  IHL_MIN      = 4'd5;
  localparam logic [3:0]  SEQ_LEN      = 4'd8;

endpackage

@@ sv/reflected_frame_matcher.sv @@
// Reflected frame matcher top level: byte-stream header checker and
// sequence extractor. Depends on rfm_pkg and reflected_frame_matcher_macros.svh.
`include "reflected_frame_matcher_macros.svh"

// Takes one received Ethernet frame byte per word on the slave stream
// (tlast on the final byte, FCS already stripped) and gives exactly one
// result word per frame on the master stream when the final byte has been
// processed. The result carries tuser = 1 when destination/source MAC,
// IPv4 destination/source and (in UDP mode) the UDP port pair match the
// configured local/peer values, the ethertype is IPv4 after at most one
// 802.1Q tag, the IHL is at least 5, and eight payload bytes were seen;
// tdata then holds those eight bytes as a big-endian sequence number,
// otherwise tdata is zero. Throughput is one byte per clock unless a final
// byte waits: a byte goes into an input register, is checked against the
// frame state from there, and a final byte then loads the result register.
// Only a final byte can wait, and only while the previous result is still
// unread; while that result sits in the output register the pipeline keeps
// accepting until a final byte reaches the input register. Registers are
// written through the cfg port at any time ready is high (always), but are
// meant to change only between frames. No reset sweep is needed.
module reflected_frame_matcher
  import rfm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // frame bytes in
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] data_byte
  input  logic                s_axis_tlast_i,  // end_of_frame
  // results out
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [SeqW-1:0]     m_axis_tdata_o,  // [63:0] sequence_res
  output logic                m_axis_tuser_o   // [0] matched
);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [47:0] local_mac_q, peer_mac_q;
  logic [31:0] local_addr_q, peer_addr_q;
  logic [15:0] local_port_q, peer_port_q;
  logic        udp_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_mac_q  <= '0;
      peer_mac_q   <= '0;
      local_addr_q <= '0;
      peer_addr_q  <= '0;
      local_port_q <= '0;
      peer_port_q  <= '0;
      udp_mode_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LOCAL_MAC:  local_mac_q  <= cfg_data_i[47:0];
        CFG_PEER_MAC:   peer_mac_q   <= cfg_data_i[47:0];
        CFG_LOCAL_ADDR: local_addr_q <= cfg_data_i[31:0];
        CFG_PEER_ADDR:  peer_addr_q  <= cfg_data_i[31:0];
        CFG_LOCAL_PORT: local_port_q <= cfg_data_i[15:0];
        CFG_PEER_PORT:  peer_port_q  <= cfg_data_i[15:0];
        CFG_UDP_MODE:   udp_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic       out_valid_q;

  // non-final bytes never wait; a final byte waits for a free result slot
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_last_q  <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // per-frame state
  // ---------------------------------------------------------------------
  logic [PosW-1:0] pos_q, pos_d;
  logic            mismatch_q, mismatch_d;
  logic            vlan_q, vlan_d;
  logic [15:0]     etype_q, etype_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [PosW-1:0] pstart_q, pstart_d;
  logic [SeqW-1:0] seq_q, seq_d;
  logic [3:0]      seq_cnt_q, seq_cnt_d;

  // byte decode helpers
  logic [PosW-1:0] l3, rel, l4, src_idx, port_rel;
  logic [2:0]      dst_sel, src_sel;
  logic [1:0]      addr_sel;
  logic [7:0]      want_byte, b;
  logic [15:0]     want_port;
  logic            fail, in_l3, ok;

  assign b        = in_byte_q;
  assign l3       = vlan_q ? L3_VLAN_OFS : L3_OFS;
  assign rel      = pos_q - l3;
  assign l4       = l3 + {1'b0, ihl_q, 2'b00};
  assign dst_sel  = 3'd5 - pos_q[2:0];
  assign src_idx  = pos_q - MAC_SRC_OFS;
  assign src_sel  = 3'd5 - src_idx[2:0];
  assign addr_sel = 2'd3 - rel[1:0];
  assign port_rel = pos_q - l4;
  assign want_port = port_rel[1] ? local_port_q : peer_port_q;
  // after the ethertype, and past the tag when one was seen
  assign in_l3    = (pos_q >= L3_OFS) && !(vlan_q && pos_q < L3_VLAN_OFS);

  always_comb begin
    fail      = 1'b0;
    want_byte = 8'h00;
    vlan_d    = vlan_q;
    etype_d   = etype_q;
    ihl_d     = ihl_q;
    pstart_d  = pstart_q;
    seq_d     = seq_q;
    seq_cnt_d = seq_cnt_q;

    if (pos_q < MAC_SRC_OFS) begin
      want_byte = local_mac_q[{dst_sel, 3'b000} +: 8];
      fail      = (want_byte != b);
    end else if (pos_q < ETYPE_OFS) begin
      want_byte = peer_mac_q[{src_sel, 3'b000} +: 8];
      fail      = (want_byte != b);
    end else if (pos_q < L3_OFS) begin
      etype_d = {etype_q[7:0], b};
      if (pos_q == ETYPE_LO_OFS) begin
        if (etype_d == ETYPE_VLAN) vlan_d = 1'b1;
        else fail = (etype_d != ETYPE_IPV4);
      end
    end else if (!in_l3) begin
      // tag control bytes are skipped, the inner ethertype is checked
      if (pos_q >= VLAN_ET_OFS) begin
        etype_d = {etype_q[7:0], b};
        if (pos_q == VLAN_ET_LO) fail = (etype_d != ETYPE_IPV4);
      end
    end else if (rel == '0) begin
      ihl_d    = b[3:0];
      fail     = (b[3:0] < IHL_MIN);
      pstart_d = l3 + {1'b0, b[3:0], 2'b00} + (udp_mode_q ? UDP_HEADER_BYTES : '0);
    end else begin
      if (rel == IP_PROTO_REL && udp_mode_q && b != IP_PROTO_UDP) fail = 1'b1;
      if (rel >= IP_SRC_REL && rel < IP_DST_REL) begin
        want_byte = peer_addr_q[{addr_sel, 3'b000} +: 8];
        fail      = fail | (want_byte != b);
      end else if (rel >= IP_DST_REL && rel < IP_END_REL) begin
        want_byte = local_addr_q[{addr_sel, 3'b000} +: 8];
        fail      = fail | (want_byte != b);
      end
      if (ihl_q >= IHL_MIN) begin
        // port pair, only when the payload was placed after a UDP header
        if (pstart_q == l4 + UDP_HEADER_BYTES && pos_q >= l4 && pos_q < l4 + 7'd4) begin
          if (port_rel[0]) fail = fail | (want_port[7:0] != b);
          else fail = fail | (want_port[15:8] != b);
        end
        if (pos_q >= pstart_q && seq_cnt_q < SEQ_LEN) begin
          seq_d     = {seq_q[SeqW-9:0], b};
          seq_cnt_d = seq_cnt_q + 4'd1;
        end
      end
    end

    mismatch_d = mismatch_q | fail;
    pos_d      = (pos_q < POS_MAX) ? pos_q + 7'd1 : pos_q;
  end

  assign ok = !mismatch_d && (seq_cnt_d == SEQ_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      mismatch_q <= 1'b0;
      vlan_q     <= 1'b0;
      etype_q    <= '0;
      ihl_q      <= '0;
      pstart_q   <= '0;
      seq_cnt_q  <= '0;
    end else if (advance) begin
      if (in_last_q) begin
        pos_q      <= '0;
        mismatch_q <= 1'b0;
        vlan_q     <= 1'b0;
        etype_q    <= '0;
        ihl_q      <= '0;
        pstart_q   <= '0;
        seq_cnt_q  <= '0;
      end else begin
        pos_q      <= pos_d;
        mismatch_q <= mismatch_d;
        vlan_q     <= vlan_d;
        etype_q    <= etype_d;
        ihl_q      <= ihl_d;
        pstart_q   <= pstart_d;
        seq_cnt_q  <= seq_cnt_d;
      end
    end
  end

  // sequence bytes are only read once all eight have been shifted in
  always_ff @(posedge clk_i) begin
    if (advance) begin
      seq_q <= seq_d;
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  logic            out_matched_q;
  logic [SeqW-1:0] out_seq_q;
  logic            out_load;

  assign out_load = advance && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_matched_q <= ok;
      out_seq_q     <= ok ? seq_d : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_matched_q;
  assign m_axis_tdata_o  = out_seq_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `RFM_ASSERT_NOW(a_unmatched_zero, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0)
  `RFM_ASSERT_NOW(a_mid_byte_no_stall, in_valid_q && !in_last_q, advance)
  `RFM_ASSERT_NEXT(a_frame_cleared, out_load, pos_q == '0 && !mismatch_q && seq_cnt_q == '0)
  `RFM_ASSERT_NOW(a_seq_cnt_bound, 1'b1, seq_cnt_q <= SEQ_LEN)

endmodule

@@ verif/reflected_frame_matcher_tb.sv @@
// Self-checking testbench for reflected_frame_matcher: streams Ethernet frames bytewise,
// predicts the per-frame match result and sequence number, and checks every result word.
// Depends on rfm_pkg and the reflected_frame_matcher RTL.
module reflected_frame_matcher_tb
  import rfm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT   = 2000;  // cycles with no accepted word
  localparam int unsigned SETTLE_CYCLES    = 10;    // result passes the input and result registers after tlast
  localparam int unsigned HOLD_OFF_CYCLES  = 300;   // long receiver stall
  localparam int unsigned BYTE_TARGET      = 1700;
  localparam int unsigned MIN_RAND_FRAMES  = 16;
  localparam int unsigned FRAMES_PER_PHASE = 4;
  localparam int unsigned MAX_REPORTED     = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  typedef struct packed {
    logic        matched;
    logic [63:0] seq;
  } seq_report_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_BITFLIP,
    FLAW_TRUNCATE,
    FLAW_SMALL_IHL,
    FLAW_NESTED_TAG,
    FLAW_BAD_ETYPE,
    FLAW_NOISE
  } frame_flaw_e;

  // DUT ports
  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = '0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [SeqW-1:0]     m_axis_tdata_o;
  logic                m_axis_tuser_o;

  reflected_frame_matcher uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Register copies the predictor checks against
  logic [47:0] want_dst_mac    = '0;
  logic [47:0] want_src_mac    = '0;
  logic [31:0] want_dst_ip     = '0;
  logic [31:0] want_src_ip     = '0;
  logic [15:0] want_local_port = '0;
  logic [15:0] want_peer_port  = '0;
  logic        want_udp        = 1'b0;

  // Per-frame parse state of the predictor, cleared after every tlast
  logic [6:0]  rx_pos       = '0;
  logic        rx_bad       = 1'b0;
  logic        rx_tagged    = 1'b0;
  logic [15:0] rx_etype     = '0;
  logic [3:0]  rx_ihl       = '0;
  logic [6:0]  rx_pay_start = '0;
  logic [63:0] rx_seq       = '0;
  logic [3:0]  rx_seq_cnt   = '0;

  frame_word_t tx_words[$];          // bytes waiting for the driver
  seq_report_t expected_reports[$];  // results owed by the block

  // Handshake sampling, written only at the rising edge
  logic        byte_fire = 1'b0;
  logic        res_fire  = 1'b0;
  int unsigned idle_cycles = 0;

  // Driver / receiver control
  logic        word_held    = 1'b0;
  int unsigned src_gap_left = 0;
  int unsigned snk_gap_left = 0;
  logic        src_gaps_on  = 1'b0;
  logic        sink_gaps_on = 1'b0;
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;

  // Statistics
  int unsigned errors        = 0;
  int unsigned bytes_queued  = 0;
  int unsigned frames_queued = 0;
  int unsigned rand_frames   = 0;
  int unsigned results_seen  = 0;
  int unsigned matched_seen  = 0;
  int unsigned settings_used = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void log_error(input string what);
    errors++;
    if (errors <= MAX_REPORTED) $display("ERROR @%0t: %s", $realtime, what);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    else if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Predictor: parse one accepted byte, queue the frame result on tlast
  task automatic track_byte(input logic [7:0] b, input logic eof);
    int          p;
    int          l3;
    int          rel;
    int          l4;
    int          k;
    logic [15:0] port;
    seq_report_t rep;
    p = rx_pos;
    if (p < 6) begin
      if (want_dst_mac[47-8*p -: 8] != b) rx_bad = 1'b1;
    end else if (p < 12) begin
      if (want_src_mac[47-8*(p-6) -: 8] != b) rx_bad = 1'b1;
    end else if (p < 14) begin
      rx_etype = {rx_etype[7:0], b};
      if (p == 13) begin
        if (rx_etype == ETYPE_VLAN) rx_tagged = 1'b1;
        else if (rx_etype != ETYPE_IPV4) rx_bad = 1'b1;
      end
    end else if (rx_tagged && p < 18) begin
      // TCI bytes are skipped, inner ethertype must be IPv4
      if (p >= 16) begin
        rx_etype = {rx_etype[7:0], b};
        if (p == 17 && rx_etype != ETYPE_IPV4) rx_bad = 1'b1;
      end
    end else begin
      l3  = rx_tagged ? 18 : 14;
      rel = p - l3;
      if (rel == 0) begin
        rx_ihl = b[3:0];
        if (rx_ihl < IHL_MIN) rx_bad = 1'b1;
        rx_pay_start = 7'(l3 + 4 * rx_ihl + (want_udp ? 8 : 0));
      end else begin
        if (rel == 9 && want_udp && b != IP_PROTO_UDP) rx_bad = 1'b1;
        if (rel >= 12 && rel < 16) begin
          if (want_src_ip[31-8*(rel-12) -: 8] != b) rx_bad = 1'b1;
        end else if (rel >= 16 && rel < 20) begin
          if (want_dst_ip[31-8*(rel-16) -: 8] != b) rx_bad = 1'b1;
        end
        if (rx_ihl >= IHL_MIN) begin
          l4 = l3 + 4 * rx_ihl;
          // port check follows the placement chosen at the IHL byte
          if (rx_pay_start == l4 + 8 && p >= l4 && p < l4 + 4) begin
            k    = p - l4;
            port = (k < 2) ? want_peer_port : want_local_port;
            if (((k & 1) ? port[7:0] : port[15:8]) != b) rx_bad = 1'b1;
          end
          if (p >= rx_pay_start && rx_seq_cnt < SEQ_LEN) begin
            rx_seq     = {rx_seq[55:0], b};
            rx_seq_cnt = rx_seq_cnt + 4'd1;
          end
        end
      end
    end
    if (rx_pos < POS_MAX) rx_pos = rx_pos + 7'd1;
    if (eof) begin
      rep.matched = !rx_bad && rx_seq_cnt == SEQ_LEN;
      rep.seq     = rep.matched ? rx_seq : 64'd0;
      expected_reports.push_back(rep);
      rx_pos       = '0;
      rx_bad       = 1'b0;
      rx_tagged    = 1'b0;
      rx_etype     = '0;
      rx_ihl       = '0;
      rx_pay_start = '0;
      rx_seq       = '0;
      rx_seq_cnt   = '0;
    end
  endtask

  // Sample both streams at the rising edge, predict and compare
  always @(posedge clk_i) begin : sample_ports
    seq_report_t want_rep;
    byte_fire = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    res_fire  = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (byte_fire) track_byte(s_axis_tdata_i, s_axis_tlast_i);
    if (res_fire) begin
      if (expected_reports.size() == 0) begin
        log_error($sformatf("unexpected result word matched=%0b seq=%h",
                            m_axis_tuser_o, m_axis_tdata_o));
      end else begin
        want_rep = expected_reports.pop_front();
        if (m_axis_tuser_o !== want_rep.matched || m_axis_tdata_o !== want_rep.seq)
          log_error($sformatf("result %0d: expected matched=%0b seq=%h, got matched=%0b seq=%h",
                              results_seen, want_rep.matched, want_rep.seq,
                              m_axis_tuser_o, m_axis_tdata_o));
        if (want_rep.matched) matched_seen++;
      end
      results_seen++;
    end
    if (byte_fire || res_fire || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
  end

  // Byte driver: holds a word until taken, then an optional random gap
  always @(negedge clk_i) begin : drive_bytes
    frame_word_t w;
    logic        nxt_valid;
    if (byte_fire) word_held = 1'b0;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (word_held) begin
      nxt_valid = 1'b1;
    end else if (src_gap_left > 0) begin
      src_gap_left--;
      nxt_valid = 1'b0;
    end else if (tx_words.size() > 0) begin
      w = tx_words.pop_front();
      s_axis_tdata_i <= w.data;
      s_axis_tlast_i <= w.last;
      word_held = 1'b1;
      nxt_valid = 1'b1;
      if (src_gaps_on && $urandom_range(0, 3) == 0) src_gap_left = pick_gap();
    end else begin
      nxt_valid = 1'b0;
    end
    s_axis_tvalid_i <= nxt_valid;
  end

  // Result receiver: random stalls plus a requested long hold-off
  always @(negedge clk_i) begin
    if (snk_gap_left > 0) begin
      snk_gap_left--;
      m_axis_tready_i <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      snk_gap_left = HOLD_OFF_CYCLES - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
      snk_gap_left = pick_gap() - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Watchdog: nothing accepted for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_LOCAL_MAC:  want_dst_mac    = value[47:0];
      CFG_PEER_MAC:   want_src_mac    = value[47:0];
      CFG_LOCAL_ADDR: want_dst_ip     = value[31:0];
      CFG_PEER_ADDR:  want_src_ip     = value[31:0];
      CFG_LOCAL_PORT: want_local_port = value[15:0];
      CFG_PEER_PORT:  want_peer_port  = value[15:0];
      CFG_UDP_MODE:   want_udp        = value[0];
      default: ;
    endcase
  endtask

  // Full register set; only called while the block is idle
  task automatic program_regs(input logic [47:0] dst_mac, input logic [47:0] src_mac,
                              input logic [31:0] dst_ip, input logic [31:0] src_ip,
                              input logic [15:0] our_port, input logic [15:0] far_port,
                              input logic udp);
    write_reg(CFG_LOCAL_MAC, dst_mac);
    write_reg(CFG_PEER_MAC, src_mac);
    write_reg(CFG_LOCAL_ADDR, {16'd0, dst_ip});
    write_reg(CFG_PEER_ADDR, {16'd0, src_ip});
    write_reg(CFG_LOCAL_PORT, {32'd0, our_port});
    write_reg(CFG_PEER_PORT, {32'd0, far_port});
    write_reg(CFG_UDP_MODE, {47'd0, udp});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Builds a frame for the current registers, optionally damaged, and queues its bytes
  task automatic build_frame(input logic with_tag, input int ihl, input int pay_len,
                             input frame_flaw_e flaw);
    logic [7:0]  fb[$];
    logic [15:0] et;
    frame_word_t w;
    int          i;
    int          hdr_end;
    int          ntags;
    int          cut;
    for (i = 0; i < 6; i++) fb.push_back(want_dst_mac[47-8*i -: 8]);
    for (i = 0; i < 6; i++) fb.push_back(want_src_mac[47-8*i -: 8]);
    ntags = with_tag + (flaw == FLAW_NESTED_TAG ? 1 : 0);
    for (i = 0; i < ntags; i++) begin
      fb.push_back(ETYPE_VLAN[15:8]);
      fb.push_back(ETYPE_VLAN[7:0]);
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(8'($urandom_range(0, 255)));
    end
    if (flaw == FLAW_BAD_ETYPE) begin
      do et = 16'($urandom_range(0, 65535)); while (et == ETYPE_IPV4 || et == ETYPE_VLAN);
    end else begin
      et = ETYPE_IPV4;
    end
    fb.push_back(et[15:8]);
    fb.push_back(et[7:0]);
    // IPv4 header; version nibble is random since it is not checked
    if (flaw == FLAW_SMALL_IHL)
      fb.push_back({4'($urandom_range(0, 15)), 4'($urandom_range(0, 4))});
    else
      fb.push_back({4'($urandom_range(0, 15)), 4'(ihl)});
    for (i = 0; i < 8; i++) fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back((want_udp || $urandom_range(0, 1)) ? IP_PROTO_UDP : 8'($urandom_range(0, 255)));
    fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(8'($urandom_range(0, 255)));
    for (i = 0; i < 4; i++) fb.push_back(want_src_ip[31-8*i -: 8]);
    for (i = 0; i < 4; i++) fb.push_back(want_dst_ip[31-8*i -: 8]);
    for (i = 0; i < 4 * (ihl - 5); i++) fb.push_back(8'($urandom_range(0, 255)));
    if (want_udp) begin
      fb.push_back(want_peer_port[15:8]);
      fb.push_back(want_peer_port[7:0]);
      fb.push_back(want_local_port[15:8]);
      fb.push_back(want_local_port[7:0]);
      for (i = 0; i < 4; i++) fb.push_back(8'($urandom_range(0, 255)));
    end
    hdr_end = fb.size();
    for (i = 0; i < pay_len; i++) fb.push_back(8'($urandom_range(0, 255)));
    case (flaw)
      FLAW_BITFLIP: begin
        i = $urandom_range(0, hdr_end - 1);
        fb[i] = fb[i] ^ (8'd1 << $urandom_range(0, 7));
      end
      FLAW_TRUNCATE: begin
        cut = $urandom_range(1, fb.size() - 1);
        while (fb.size() > cut) void'(fb.pop_back());
      end
      FLAW_NOISE: begin
        fb.delete();
        cut = $urandom_range(1, 60);
        for (i = 0; i < cut; i++) fb.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    for (i = 0; i < fb.size(); i++) begin
      w.data = fb[i];
      w.last = (i == fb.size() - 1);
      tx_words.push_back(w);
    end
    bytes_queued += fb.size();
    frames_queued++;
  endtask

  // Wait until every byte is taken and every result has come, then let the pipe settle
  task automatic drain();
    while (tx_words.size() != 0 || word_held || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : run_test
    frame_word_t w;
    int          r;
    int          pay;
    frame_flaw_e flaw;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset-value registers, raw mode
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    build_frame(1'b0, 5, 8, FLAW_NONE);
    w.data = 8'hFF;
    w.last = 1'b1;
    tx_words.push_back(w);  // one-byte frame
    bytes_queued++;
    frames_queued++;
    drain();

    // Directed: all-ones registers, UDP mode
    program_regs('1, '1, '1, '1, '1, '1, 1'b1);
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    build_frame(1'b0, 5, 8, FLAW_NONE);
    build_frame(1'b1, 15, 12, FLAW_NONE);
    build_frame(1'b0, 5, 8, FLAW_SMALL_IHL);
    build_frame(1'b1, 5, 8, FLAW_NESTED_TAG);
    build_frame(1'b0, 5, 8, FLAW_BAD_ETYPE);
    build_frame(1'b1, 5, 8, FLAW_BAD_ETYPE);
    build_frame(1'b0, 5, 7, FLAW_NONE);      // one sequence byte short
    build_frame(1'b1, 6, 110, FLAW_NONE);    // runs past the saturated position
    build_frame(1'b0, 5, 8, FLAW_TRUNCATE);
    drain();

    // Directed: all-zero registers written explicitly, raw mode
    program_regs('0, '0, '0, '0, '0, '0, 1'b0);
    build_frame(1'b1, 5, 9, FLAW_NONE);
    build_frame(1'b0, 7, 0, FLAW_NONE);
    build_frame(1'b0, 5, 8, FLAW_NOISE);
    drain();

    // Random phases, each with a fresh register set
    while (bytes_queued < BYTE_TARGET || rand_frames < MIN_RAND_FRAMES) begin
      program_regs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom,
                   16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      src_gaps_on  = $urandom_range(0, 3) != 0;
      sink_gaps_on = $urandom_range(0, 3) != 0;
      // first random phase: receiver stalls long so the block backs up its input
      if (rand_frames == 0) holds_asked++;
      repeat (FRAMES_PER_PHASE) begin
        r = $urandom_range(0, 19);
        if (r == 0) pay = $urandom_range(0, 7);
        else if (r == 1) pay = $urandom_range(60, 120);
        else pay = $urandom_range(8, 16);
        r = $urandom_range(0, 99);
        if (r < 60) flaw = FLAW_NONE;
        else if (r < 72) flaw = FLAW_BITFLIP;
        else if (r < 78) flaw = FLAW_TRUNCATE;
        else if (r < 84) flaw = FLAW_SMALL_IHL;
        else if (r < 88) flaw = FLAW_NESTED_TAG;
        else if (r < 92) flaw = FLAW_BAD_ETYPE;
        else flaw = FLAW_NOISE;
        build_frame($urandom_range(0, 2) == 0,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5, pay, flaw);
        rand_frames++;
      end
      drain();
    end

    if (expected_reports.size() != 0)
      log_error($sformatf("%0d results never arrived", expected_reports.size()));
    $display("Covered %0d frames (%0d bytes) under %0d register settings:",
             frames_queued, bytes_queued, settings_used);
    $display("  %0d results, %0d matched.", results_seen, matched_seen);
    if (errors > MAX_REPORTED)
      $display("%0d mismatches in total, only the first %0d shown.", errors, MAX_REPORTED);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ reflected_frame_matcher.f @@
+incdir+sv
sv/rfm_pkg.sv
sv/reflected_frame_matcher.sv
verif/reflected_frame_matcher_tb.sv
